@@ hw/rtl/sdf_pkg.sv @@
// Shared types and constants for the signed decimal formatter.
// Holds the controller state type, the command and status structs and the ASCII codes.
// Depends on nothing.
package sdf_pkg;

  localparam int unsigned MaxFieldDefault = 64;
  localparam int unsigned ValueWidth      = 32;
  localparam int unsigned FieldInWidth    = 7;
  localparam int unsigned CharWidth       = 8;
  localparam int unsigned BcdDigits       = 10;
  localparam int unsigned BcdWidth        = 4 * BcdDigits;
  localparam int unsigned BitsPerStep     = 4;
  localparam int unsigned ConvSteps       = ValueWidth / BitsPerStep;
  localparam int unsigned ConvCntWidth    = $clog2(ConvSteps);

  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharSpace = 8'h20;
  localparam logic [CharWidth-1:0] CharMinus = 8'h2d;
  localparam logic [CharWidth-1:0] CharPlus  = 8'h2b;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StPlan,
    StEmit
  } state_e;

  typedef struct packed {
    logic load;
    logic conv;
    logic plan;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic empty;
    logic last;
  } dp_status_t;

endpackage

@@ hw/rtl/sdf_datapath.sv @@
// Datapath of the signed decimal formatter: binary to BCD conversion, field layout
// and character selection. Driven by sdf_ctrl through sdf_pkg::dp_cmd_t.
// Depends on sdf_pkg.
module sdf_datapath #(
  parameter int unsigned MAX_FIELD = sdf_pkg::MaxFieldDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sdf_pkg::dp_cmd_t                     cmd_i,
  output sdf_pkg::dp_status_t                  status_o,
  input  logic signed [sdf_pkg::ValueWidth-1:0]   value_i,
  input  logic [sdf_pkg::FieldInWidth-1:0]        min_width_i,
  input  logic signed [sdf_pkg::FieldInWidth-1:0] min_digits_i,
  input  logic                                 left_align_i,
  input  logic                                 pad_zero_i,
  input  logic                                 plus_sign_i,
  input  logic                                 blank_sign_i,
  output logic [sdf_pkg::CharWidth-1:0]        char_out_o,
  output logic                                 is_last_o
);

  localparam int unsigned CW = $clog2(MAX_FIELD + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned VW = sdf_pkg::ValueWidth;
  localparam int unsigned BW = sdf_pkg::BcdWidth;
  localparam int unsigned IW = sdf_pkg::FieldInWidth;
  localparam int unsigned NW = sdf_pkg::ConvCntWidth;

  function automatic logic [BW-1:0] bcd_shift(input logic [BW-1:0] bcd, input logic in_bit);
    logic [BW-1:0] adj;
    adj = bcd;
    for (int i = 0; i < int'(sdf_pkg::BcdDigits); i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BW-2:0], in_bit};
  endfunction

  logic [VW-1:0]                    mag_q;
  logic [BW-1:0]                    bcd_q;
  logic [NW-1:0]                    cnt_q;
  logic [CW-1:0]                    k_q;
  logic                             neg_q, plus_q, blank_q, left_q, zpad_q, has_prec_q;
  logic [CW-1:0]                    prec_q, width_q;
  logic [CW-1:0]                    lpad_q, zeros_q, rpad_q;
  logic [3:0]                       ndig_q;
  logic                             nsign_q;

  logic [VW-1:0] value_u;
  logic [VW-1:0] mag_in;
  logic          has_prec_in;
  logic [IW-1:0] prec_in;
  logic [IW-1:0] prec_sat;
  logic [IW-1:0] width_sat;
  logic [BW-1:0] bcd_c;

  always_comb begin
    value_u     = value_i;
    mag_in      = value_u[VW-1] ? (~value_u + VW'(1)) : value_u;
    has_prec_in = ~min_digits_i[IW-1];
    prec_in     = has_prec_in ? {1'b0, min_digits_i[IW-2:0]} : '0;
    prec_sat    = (prec_in > IW'(MAX_FIELD - 1)) ? IW'(MAX_FIELD - 1) : prec_in;
    width_sat   = (min_width_i > IW'(MAX_FIELD)) ? IW'(MAX_FIELD) : min_width_i;
  end

  always_comb begin
    bcd_c = bcd_q;
    for (int j = 0; j < int'(sdf_pkg::BitsPerStep); j++) begin
      bcd_c = bcd_shift(bcd_c, mag_q[VW-1-j]);
    end
  end

  // Field layout
  logic [3:0]    ndig_c;
  logic          nsign_c;
  logic [SW-1:0] zeros_w, body_w, fill_w, width_w, prec_w, ndig_w;

  always_comb begin
    ndig_c = '0;
    for (int i = 0; i < int'(sdf_pkg::BcdDigits); i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        ndig_c = 4'(i + 1);
      end
    end
    if (ndig_c == 4'd0 && !(has_prec_q && prec_q == '0)) begin
      ndig_c = 4'd1;
    end
    nsign_c = neg_q | plus_q | blank_q;
    prec_w  = SW'(prec_q);
    ndig_w  = SW'(ndig_c);
    width_w = SW'(width_q);
    zeros_w = (prec_w > ndig_w) ? (prec_w - ndig_w) : '0;
    body_w  = SW'(nsign_c) + zeros_w + ndig_w;
    fill_w  = (width_w > body_w) ? (width_w - body_w) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      k_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.conv) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.plan) begin
        k_q <= '0;
      end else if (cmd_i.emit) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q      <= mag_in;
      bcd_q      <= '0;
      neg_q      <= value_u[VW-1];
      plus_q     <= plus_sign_i;
      blank_q    <= blank_sign_i;
      left_q     <= left_align_i;
      zpad_q     <= pad_zero_i;
      has_prec_q <= has_prec_in;
      prec_q     <= CW'(prec_sat);
      width_q    <= CW'(width_sat);
    end else if (cmd_i.conv) begin
      mag_q <= mag_q << sdf_pkg::BitsPerStep;
      bcd_q <= bcd_c;
    end
    if (cmd_i.plan) begin
      ndig_q  <= ndig_c;
      nsign_q <= nsign_c;
      if (left_q) begin
        lpad_q  <= '0;
        zeros_q <= CW'(zeros_w);
        rpad_q  <= CW'(fill_w);
      end else if (zpad_q && !has_prec_q) begin
        lpad_q  <= '0;
        zeros_q <= CW'(zeros_w + fill_w);
        rpad_q  <= '0;
      end else begin
        lpad_q  <= CW'(fill_w);
        zeros_q <= CW'(zeros_w);
        rpad_q  <= '0;
      end
    end
  end

  // Character selection
  logic [SW-1:0] b1, b2, b3, b4, total, k_w, didx_w;
  logic [3:0]    digit;

  always_comb begin
    k_w    = SW'(k_q);
    b1     = SW'(lpad_q);
    b2     = b1 + SW'(nsign_q);
    b3     = b2 + SW'(zeros_q);
    b4     = b3 + SW'(ndig_q);
    total  = b4 + SW'(rpad_q);
    didx_w = b4 - SW'(1) - k_w;
    digit  = '0;
    for (int i = 0; i < int'(sdf_pkg::BcdDigits); i++) begin
      if (didx_w[3:0] == 4'(i)) begin
        digit = bcd_q[4*i +: 4];
      end
    end
    if (k_w < b1) begin
      char_out_o = sdf_pkg::CharSpace;
    end else if (k_w < b2) begin
      char_out_o = neg_q ? sdf_pkg::CharMinus :
                   (plus_q ? sdf_pkg::CharPlus : sdf_pkg::CharSpace);
    end else if (k_w < b3) begin
      char_out_o = sdf_pkg::CharZero;
    end else if (k_w < b4) begin
      char_out_o = sdf_pkg::CharZero + {4'd0, digit};
    end else begin
      char_out_o = sdf_pkg::CharSpace;
    end
    is_last_o          = (k_w + SW'(1)) == total;
    status_o.last      = is_last_o;
    status_o.empty     = total == '0;
    status_o.conv_done = cnt_q == NW'(sdf_pkg::ConvSteps - 1);
  end

endmodule

@@ hw/rtl/sdf_ctrl.sv @@
// Controller of the signed decimal formatter: sequences load, conversion,
// layout and emission of one item. Talks to sdf_datapath by command and status.
// Depends on sdf_pkg.
module sdf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output logic                strobe_o,
  output sdf_pkg::dp_cmd_t    cmd_o,
  input  sdf_pkg::dp_status_t status_i
);

  sdf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdf_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    busy_o   = 1'b1;
    strobe_o = 1'b0;
    unique case (state_q)
      sdf_pkg::StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = sdf_pkg::StConv;
        end
      end
      sdf_pkg::StConv: begin
        cmd_o.conv = 1'b1;
        if (status_i.conv_done) begin
          state_d = sdf_pkg::StPlan;
        end
      end
      sdf_pkg::StPlan: begin
        cmd_o.plan = 1'b1;
        state_d    = sdf_pkg::StEmit;
      end
      sdf_pkg::StEmit: begin
        cmd_o.emit = 1'b1;
        strobe_o   = ~status_i.empty;
        if (status_i.empty || status_i.last) begin
          state_d = sdf_pkg::StIdle;
        end
      end
      default: state_d = sdf_pkg::StIdle;
    endcase
  end

endmodule

@@ hw/rtl/signed_decimal_formatter.sv @@
// Top level of the signed decimal formatter.
// Instantiates sdf_ctrl and sdf_datapath; depends on sdf_pkg.
//
// Usage:
//   An item (value_i and its format fields) is taken at a rising edge with
//   start_i high and busy_o low. busy_o then stays high until the item is done.
//   The item's printf-style decimal text comes out one character per cycle on
//   char_out_o, each marked by strobe_o for exactly one cycle; is_last_o flags
//   the final character. The receiver cannot stall; every strobed cycle is taken.
//   An item whose text is empty gives no strobe at all.
// Operation:
//   BCD conversion takes 4 bits per cycle through a shift-add-3 unit; field layout
//   follows, then the characters are output one per cycle.
//   The first character appears once conversion and layout are done; busy_o
//   stays high through the last character and falls in the cycle after it. A new
//   item is taken only while busy_o is low, so items never overlap.
// Reset:
//   rst_ni clears the controller to idle and drops busy_o and strobe_o at once.
module signed_decimal_formatter #(
  parameter int unsigned MAX_FIELD = sdf_pkg::MaxFieldDefault
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  output logic                                    busy_o,
  input  logic signed [sdf_pkg::ValueWidth-1:0]   value_i,
  input  logic [sdf_pkg::FieldInWidth-1:0]        min_width_i,
  input  logic signed [sdf_pkg::FieldInWidth-1:0] min_digits_i,
  input  logic                                    left_align_i,
  input  logic                                    pad_zero_i,
  input  logic                                    plus_sign_i,
  input  logic                                    blank_sign_i,
  output logic                                    strobe_o,
  output logic [sdf_pkg::CharWidth-1:0]           char_out_o,
  output logic                                    is_last_o
);

  sdf_pkg::dp_cmd_t    cmd;
  sdf_pkg::dp_status_t status;
  logic                last_raw;

  sdf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .strobe_o (strobe_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  sdf_datapath #(
    .MAX_FIELD (MAX_FIELD)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .value_i      (value_i),
    .min_width_i  (min_width_i),
    .min_digits_i (min_digits_i),
    .left_align_i (left_align_i),
    .pad_zero_i   (pad_zero_i),
    .plus_sign_i  (plus_sign_i),
    .blank_sign_i (blank_sign_i),
    .char_out_o   (char_out_o),
    .is_last_o    (last_raw)
  );

  assign is_last_o = last_raw & strobe_o;

  a_strobe_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy_o)
    else $error("strobe outside a busy item");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not raise busy");

  a_last_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && is_last_o) |=> (!strobe_o && !busy_o))
    else $error("activity after the last character");

  a_contiguous : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !is_last_o) |=> strobe_o)
    else $error("gap inside an item's characters");

  a_busy_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && !strobe_o && $past(strobe_o)) |-> $past(is_last_o))
    else $error("emission stopped before the last character");

endmodule
